[hdl/bffa_pkg.sv]
`timescale 1ns / 1ps

package bffa_pkg;

  // Bitmap geometry: one memory word holds this many item bits.
  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned POS_W     = 6;

  // Fixed field widths of the request and response transactions.
  localparam int unsigned NUM_W = 14;
  localparam int unsigned ST_W  = 2;

  // Default map size and the reset value of the limit register.
  localparam int unsigned    MAP_BITS_DEF = 8192;
  localparam logic [13:0]    LIMIT_RESET  = 14'd8192;

  // Operation codes of the func field.
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Response status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  // Result of examining one bitmap word.
  typedef struct packed {
    logic             found;  // a free item lies in this word below the limit
    logic [POS_W-1:0] pos;    // lowest free bit position in the word
    logic             last;   // this word reaches the limit, scan ends here
  } scan_res_t;

endpackage

[hdl/bffa_cfg_if.sv]
`timescale 1ns / 1ps

// Write channel for the item limit register.
interface bffa_cfg_if;
  logic        valid;
  logic        ready;
  logic [13:0] item_limit;

  modport source (output valid, output item_limit, input ready);
  modport sink   (input valid, input item_limit, output ready);
endinterface

[hdl/bffa_req_if.sv]
`timescale 1ns / 1ps

// Request channel: allocate or free one item.
interface bffa_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [13:0] item_number;

  modport source (output valid, output func, output item_number, input ready);
  modport sink   (input valid, input func, input item_number, output ready);
endinterface

[hdl/bffa_rsp_if.sv]
`timescale 1ns / 1ps

// Response channel: one transaction per request.
interface bffa_rsp_if;
  logic        valid;
  logic        ready;
  logic [13:0] granted_number;
  logic [1:0]  status;
  logic [13:0] used_count;

  modport source (output valid, output granted_number, output status,
                  output used_count, input ready);
  modport sink   (input valid, input granted_number, input status,
                  input used_count, output ready);
endinterface

[hdl/bitmap_first_fit_allocator_core.sv]
`timescale 1ns / 1ps

// First-fit allocator over a bitmap of MAP_BITS items numbered from 1, with a
// running count of allocated items. The bitmap lives in a RAM of 64-bit words
// that a small sequencer reads one word per cycle through a single word
// scanner. An allocate passes through the request, a word read, a scan of each
// word up to the first free bit or to the limit, and a response load, so it
// scans at most MAP_WORDS words (128 for the default 8192 items). A free goes
// through the request, a word read, a check and write, and a response load.
// A free whose number is zero or above the limit goes from the request
// straight to the response load. The response load waits while the previous
// response has not been taken. Requests are handled one at a time; the request
// channel is not ready while one is in progress. The response sits in an output
// register, so a new request may be taken before the previous response is
// consumed. After reset the block clears every bitmap word, one word per
// cycle, before it takes the first request. The item limit register may be
// written at any time the block is idle; the limit in use saturates to MAP_BITS.
module bitmap_first_fit_allocator_core #(
  parameter int unsigned MAP_BITS = bffa_pkg::MAP_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bffa_cfg_if.sink   cfg_i,
  bffa_req_if.sink   req_i,
  bffa_rsp_if.source rsp_o
);
  import bffa_pkg::*;

  localparam int unsigned MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned IDXW      = AW + POS_W;
  localparam int unsigned CW        = ((IDXW > NUM_W) ? IDXW : NUM_W) + 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_WORDS - 1);

  typedef enum logic [5:0] {
    S_CLR  = 6'b000001,
    S_IDLE = 6'b000010,
    S_RD   = 6'b000100,
    S_SCAN = 6'b001000,
    S_FREE = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  state_e           state_q, state_d;
  logic [AW-1:0]    addr_q, addr_d;
  logic [NUM_W-1:0] used_q, used_d;
  logic [NUM_W-1:0] limit_q, limit_d;
  logic             rsp_valid_q, rsp_valid_d;

  logic             func_q, func_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [NUM_W-1:0] res_num_q, res_num_d;
  status_e          res_st_q, res_st_d;
  logic [NUM_W-1:0] rsp_num_q, rsp_num_d;
  status_e          rsp_st_q, rsp_st_d;
  logic [NUM_W-1:0] rsp_used_q, rsp_used_d;

  logic [NUM_W-1:0]     lim;
  logic [IDXW-1:0]      base;
  logic [NUM_W-1:0]     free_idx;
  logic [IDXW-1:0]      free_idx_w;
  logic                 free_bad;
  logic [IDXW:0]        grant_sum;
  logic                 req_fire;
  logic                 rsp_load;
  logic                 ram_we;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;
  scan_res_t            scan;

  // Effective limit is the register saturated to the map size.
  always_comb begin
    if (CW'(limit_q) > CW'(MAP_BITS)) begin
      lim = NUM_W'(MAP_BITS);
    end else begin
      lim = limit_q;
    end
  end

  assign base       = {addr_q, {POS_W{1'b0}}};
  assign free_idx   = req_i.item_number - 1'b1;
  assign free_idx_w = IDXW'(free_idx);
  assign free_bad   = (req_i.item_number == '0) || (req_i.item_number > lim);
  assign grant_sum  = (IDXW + 1)'(base) + (IDXW + 1)'(scan.pos) + 1'b1;

  // Handshakes.
  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign req_fire    = req_i.valid && req_i.ready;
  assign rsp_load    = (state_q == S_DONE) && (!rsp_valid_q || rsp_o.ready);

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.granted_number = rsp_num_q;
  assign rsp_o.status         = rsp_st_q;
  assign rsp_o.used_count     = rsp_used_q;

  // Bitmap word storage.
  bffa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Single word scanner.
  bffa_scan #(
    .IDXW (IDXW),
    .CW   (CW)
  ) u_scan (
    .word_i  (ram_rdata),
    .base_i  (base),
    .limit_i (lim),
    .res_o   (scan)
  );

  // While scanning, fetch the next word ahead so one word is checked per cycle.
  always_comb begin
    if ((state_q == S_SCAN) && !scan.last) begin
      ram_raddr = addr_q + 1'b1;
    end else begin
      ram_raddr = addr_q;
    end
  end

  // Memory writes: clearing pass, setting a granted bit, clearing a freed bit.
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = '0;
    case (state_q)
      S_CLR: begin
        ram_we = 1'b1;
      end
      S_SCAN: begin
        ram_we    = scan.found;
        ram_wdata = ram_rdata | (WORD_BITS'(1) << scan.pos);
      end
      S_FREE: begin
        ram_we    = ram_rdata[pos_q];
        ram_wdata = ram_rdata & ~(WORD_BITS'(1) << pos_q);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Sequencer next state and datapath register updates.
  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    used_d      = used_q;
    limit_d     = limit_q;
    rsp_valid_d = rsp_valid_q;
    func_d      = func_q;
    pos_d       = pos_q;
    res_num_d   = res_num_q;
    res_st_d    = res_st_q;
    rsp_num_d   = rsp_num_q;
    rsp_st_d    = rsp_st_q;
    rsp_used_d  = rsp_used_q;

    if (cfg_i.valid && cfg_i.ready) begin
      limit_d = cfg_i.item_limit;
    end

    if (rsp_o.valid && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    case (state_q)
      S_CLR: begin
        if (addr_q == LAST_ADDR) begin
          addr_d  = '0;
          state_d = S_IDLE;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (req_fire) begin
          func_d = req_i.func;
          if (req_i.func == FUNC_ALLOC) begin
            addr_d  = '0;
            state_d = S_RD;
          end else if (free_bad) begin
            res_num_d = '0;
            res_st_d  = ST_RANGE;
            state_d   = S_DONE;
          end else begin
            addr_d  = free_idx_w[IDXW-1:POS_W];
            pos_d   = free_idx[POS_W-1:0];
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        state_d = (func_q == FUNC_ALLOC) ? S_SCAN : S_FREE;
      end
      S_SCAN: begin
        if (scan.found) begin
          used_d    = used_q + 1'b1;
          res_num_d = NUM_W'(grant_sum);
          res_st_d  = ST_OK;
          state_d   = S_DONE;
        end else if (scan.last) begin
          res_num_d = '0;
          res_st_d  = ST_FULL;
          state_d   = S_DONE;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end
      S_FREE: begin
        if (ram_rdata[pos_q]) begin
          used_d = used_q - 1'b1;
        end
        res_num_d = '0;
        res_st_d  = ST_OK;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (rsp_load) begin
          rsp_valid_d = 1'b1;
          rsp_num_d   = res_num_q;
          rsp_st_d    = res_st_q;
          rsp_used_d  = used_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      addr_q      <= '0;
      used_q      <= '0;
      limit_q     <= LIMIT_RESET;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      used_q      <= used_d;
      limit_q     <= limit_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    pos_q      <= pos_d;
    res_num_q  <= res_num_d;
    res_st_q   <= res_st_d;
    rsp_num_q  <= rsp_num_d;
    rsp_st_q   <= rsp_st_d;
    rsp_used_q <= rsp_used_d;
  end

  // A response that is not ok never carries a granted number.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.status != ST_OK) |-> (rsp_o.granted_number == '0))
    else $error("failed response carries a granted number");

  // The bitmap is never written while waiting for a request or a response slot, or while reading a word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) || (state_q == S_DONE) || (state_q == S_RD) |-> !ram_we)
    else $error("bitmap written outside an update step");

  // The used count moves only in the step that sets or clears a bit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q != $past(used_q)) |-> ($past(state_q == S_SCAN) || $past(state_q == S_FREE)))
    else $error("used count changed outside an update step");

  // The scan never runs past the last bitmap word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (addr_q <= LAST_ADDR))
    else $error("scan address beyond the bitmap");

endmodule

[hdl/bffa_ram.sv]
`timescale 1ns / 1ps

module bffa_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[hdl/bffa_scan.sv]
`timescale 1ns / 1ps

module bffa_scan #(
  parameter int unsigned IDXW = 13,
  parameter int unsigned CW   = 15
) (
  input  logic [bffa_pkg::WORD_BITS-1:0] word_i,
  input  logic [IDXW-1:0]                base_i,
  input  logic [bffa_pkg::NUM_W-1:0]     limit_i,
  output bffa_pkg::scan_res_t            res_o
);
  import bffa_pkg::*;

  logic [CW-1:0]        lim_w;
  logic [CW-1:0]        base_w;
  logic [CW-1:0]        span;
  logic [WORD_BITS-1:0] in_range;
  logic [WORD_BITS-1:0] busy;

  assign lim_w  = CW'(limit_i);
  assign base_w = CW'(base_i);
  assign span   = lim_w - base_w;

  // Bits at or above the limit count as taken so they are never granted.
  always_comb begin
    if (lim_w <= base_w) begin
      in_range = '0;
    end else if (span >= CW'(WORD_BITS)) begin
      in_range = '1;
    end else begin
      in_range = ~({WORD_BITS{1'b1}} << span[POS_W-1:0]);
    end
  end

  assign busy = word_i | ~in_range;

  // Priority search for the lowest clear bit.
  always_comb begin
    res_o.found = 1'b0;
    res_o.pos   = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (!busy[j]) begin
        res_o.found = 1'b1;
        res_o.pos   = POS_W'(j);
      end
    end
    res_o.last = (lim_w <= base_w + CW'(WORD_BITS));
  end

endmodule
